// ----- src/nonoverlap_substring_locator_assert.svh -----
// Assertion helpers; every use expects clk_i and rst_ni in scope.
`ifndef NONOVERLAP_SUBSTRING_LOCATOR_ASSERT_SVH
`define NONOVERLAP_SUBSTRING_LOCATOR_ASSERT_SVH

// Same-cycle implication.
`define NSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/nsl_pkg.sv -----
`default_nettype none

package nsl_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int PAT_BYTES       = 32;
  localparam int PAT_SEL_W       = $clog2(PAT_BYTES);

  localparam int LEN_W      = 6;
  localparam int LINE_W     = 20;
  localparam int COL_W      = 16;
  localparam int LCNT_W     = 16;
  localparam int CNT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;
  localparam logic [LCNT_W-1:0] LCNT_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_C  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 3'd4;

  typedef enum logic [1:0] {
    MODE_CHAR = 2'd0,
    MODE_EOL  = 2'd1,
    MODE_EOT  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_MATCH = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_TOTAL = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [CNT_W-1:0]  count;
  } report_t;

  typedef struct packed {
    logic step;   // shift a character through the cells
    logic clear;  // line boundary: zero the held bytes
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/nsl_text_if.sv -----
`default_nettype none

interface nsl_text_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] text_byte;

  modport source (output valid, output mode, output text_byte, input ready);
  modport sink (input valid, input mode, input text_byte, output ready);
endinterface

`default_nettype wire

// ----- src/nsl_report_if.sv -----
`default_nettype none

interface nsl_report_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    report_kind;
  logic [nsl_pkg::LINE_W-1:0]    line_number;
  logic [nsl_pkg::COL_W-1:0]     start_column;
  logic [nsl_pkg::CNT_W-1:0]     occurrence_count;

  modport source (output valid, output report_kind, output line_number,
                  output start_column, output occurrence_count, input ready);
  modport sink (input valid, input report_kind, input line_number,
                input start_column, input occurrence_count, output ready);
endinterface

`default_nettype wire

// ----- src/nsl_cfg_if.sv -----
`default_nettype none

interface nsl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nsl_pkg::CFG_IDX_W-1:0]   index;
  logic [nsl_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/nonoverlap_substring_locator.sv -----
// Finds leftmost, non-overlapping occurrences of a 1..MAX_PATTERN byte pattern
// in a character stream, per line. One item (character, end of line, end of
// text) is accepted every cycle unless input stalls; its result, if any, is
// registered in the report output buffer. A row of MAX_PATTERN cells holds the
// last bytes of the line as a shift register; each cell compares the byte
// moving into it with the pattern byte lined up to its position, and the
// compares are ANDed over the pattern length, so the rate is set by that single
// compare-and-reduce step. Because the window itself is kept, a pattern change
// in the middle of a line takes effect on the next character. A two-entry
// output buffer lets one more item in while a result is held; input stalls
// only when both entries are full.
// Pattern registers may be written only while the stream is idle.
`default_nettype none

module nonoverlap_substring_locator #(
  parameter int MAX_PATTERN = nsl_pkg::MAX_PATTERN_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  nsl_text_if.sink     in_i,
  nsl_report_if.source out_o,
  nsl_cfg_if.sink      cfg_i
);

  logic [nsl_pkg::CFG_DATA_W-1:0] pat_a_q, pat_b_q, pat_c_q, pat_d_q;
  logic [nsl_pkg::LEN_W-1:0]      len_q;
  logic [8*nsl_pkg::PAT_BYTES-1:0] pat_all;

  logic                 accept;
  logic                 skid_ready;
  logic [MAX_PATTERN-1:0] match;
  logic [MAX_PATTERN-1:0][7:0] recent;
  logic [nsl_pkg::LEN_W-1:0] len_m1;
  nsl_pkg::cell_ctrl_t  ctrl;
  logic                 res_valid;
  nsl_pkg::report_t     res;
  nsl_pkg::report_t     out_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_a_q <= '0;
      pat_b_q <= '0;
      pat_c_q <= '0;
      pat_d_q <= '0;
      len_q   <= nsl_pkg::LEN_W'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        nsl_pkg::CFG_PAT_A:   pat_a_q <= cfg_i.data;
        nsl_pkg::CFG_PAT_B:   pat_b_q <= cfg_i.data;
        nsl_pkg::CFG_PAT_C:   pat_c_q <= cfg_i.data;
        nsl_pkg::CFG_PAT_D:   pat_d_q <= cfg_i.data;
        nsl_pkg::CFG_PAT_LEN: len_q   <= cfg_i.data[nsl_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign pat_all = {pat_d_q, pat_c_q, pat_b_q, pat_a_q};

  assign in_i.ready = skid_ready;
  assign accept     = in_i.valid && skid_ready;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0]                    byte_in;
    logic [nsl_pkg::PAT_SEL_W-1:0] sel;
    if (k == 0) begin : g_first
      assign byte_in = in_i.text_byte;
    end else begin : g_rest
      assign byte_in = recent[k-1];
    end
    // position k of the window (0 newest) lines up with pattern byte len-1-k
    assign sel = len_m1[nsl_pkg::PAT_SEL_W-1:0] - nsl_pkg::PAT_SEL_W'(k);
    nsl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .byte_i     (byte_in),
      .pat_byte_i (pat_all[{sel, 3'b000} +: 8]),
      .match_o    (match[k]),
      .byte_o     (recent[k])
    );
  end

  nsl_tracker #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (in_i.mode),
    .len_i       (len_q),
    .match_i     (match),
    .len_m1_o    (len_m1),
    .ctrl_o      (ctrl),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nsl_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .ready_o     (skid_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.report_kind      = out_data.kind;
  assign out_o.line_number      = out_data.line;
  assign out_o.start_column     = out_data.col;
  assign out_o.occurrence_count = out_data.count;

endmodule

`default_nettype wire

// ----- src/nsl_cell.sv -----
`default_nettype none

// One window position: holds one recent byte of the line and compares the
// byte moving into it with the pattern byte aligned to this position.
module nsl_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nsl_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          pat_byte_i,
  output logic                match_o,
  output logic [7:0]          byte_o
);

  logic [7:0] byte_q, byte_d;

  assign match_o = (byte_i == pat_byte_i);

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.step) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ----- src/nsl_tracker.sv -----
`default_nettype none

module nsl_tracker #(
  parameter int MAX_PATTERN = nsl_pkg::MAX_PATTERN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [1:0]                  mode_i,
  input  logic [nsl_pkg::LEN_W-1:0]   len_i,
  input  logic [MAX_PATTERN-1:0]      match_i,
  output logic [nsl_pkg::LEN_W-1:0]   len_m1_o,
  output nsl_pkg::cell_ctrl_t         ctrl_o,
  output logic                        res_valid_o,
  output nsl_pkg::report_t            res_o
);

  localparam int ENS_W = nsl_pkg::COL_W + 1;

  logic [nsl_pkg::LEN_W-1:0]  bil_q, bil_d;
  logic [nsl_pkg::COL_W-1:0]  col_q, col_d;
  logic [ENS_W-1:0]           ens_q, ens_d;
  logic [nsl_pkg::LINE_W-1:0] line_q, line_d;
  logic [nsl_pkg::LCNT_W-1:0] lm_q, lm_d;
  logic [nsl_pkg::CNT_W-1:0]  tot_q, tot_d;

  logic [nsl_pkg::LEN_W-1:0]  len_eff, len_m1;
  logic [nsl_pkg::LEN_W-1:0]  bil_inc;
  logic                       win_ok;
  logic [ENS_W-1:0]           start;
  logic [ENS_W-1:0]           col_p1;
  logic                       hit;
  logic [nsl_pkg::LCNT_W-1:0] lm_inc;
  nsl_pkg::mode_e             mode;

  assign mode = nsl_pkg::mode_e'(mode_i);

  always_comb begin
    if (len_i == '0) begin
      len_eff = nsl_pkg::LEN_W'(1);
    end else if (len_i > nsl_pkg::LEN_W'(MAX_PATTERN)) begin
      len_eff = nsl_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_i;
    end
  end

  // only the first len window positions take part in the compare
  always_comb begin
    win_ok = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if ((nsl_pkg::LEN_W'(j) < len_eff) && !match_i[j]) begin
        win_ok = 1'b0;
      end
    end
  end

  assign len_m1   = len_eff - nsl_pkg::LEN_W'(1);
  assign len_m1_o = len_m1;
  assign bil_inc  = (bil_q < nsl_pkg::LEN_W'(MAX_PATTERN)) ? bil_q + nsl_pkg::LEN_W'(1)
                                                           : bil_q;
  assign col_p1 = {1'b0, col_q} + ENS_W'(1);
  // a hit implies at least len bytes in the line, so start never wraps on a hit
  assign start  = col_p1 - ENS_W'(len_eff);
  assign hit    = win_ok && (bil_inc >= len_eff) && (start >= ens_q);
  assign lm_inc = (lm_q == nsl_pkg::LCNT_MAX) ? lm_q : lm_q + nsl_pkg::LCNT_W'(1);

  always_comb begin
    bil_d        = bil_q;
    col_d        = col_q;
    ens_d        = ens_q;
    line_d       = line_q;
    lm_d         = lm_q;
    tot_d        = tot_q;
    ctrl_o       = '0;
    res_valid_o  = 1'b0;
    res_o.kind   = nsl_pkg::KIND_MATCH;
    res_o.line   = line_q;
    res_o.col    = '0;
    res_o.count  = '0;
    if (accept_i) begin
      case (mode)
        nsl_pkg::MODE_CHAR: begin
          ctrl_o.step = 1'b1;
          bil_d       = bil_inc;
          if (col_q != nsl_pkg::COL_MAX) begin
            col_d = col_q + nsl_pkg::COL_W'(1);
          end
          if (hit) begin
            ens_d       = col_p1;
            lm_d        = lm_inc;
            if (tot_q != nsl_pkg::CNT_MAX) begin
              tot_d = tot_q + nsl_pkg::CNT_W'(1);
            end
            res_valid_o = 1'b1;
            res_o.col   = start[nsl_pkg::COL_W-1:0];
            res_o.count = nsl_pkg::CNT_W'(lm_inc);
          end
        end
        nsl_pkg::MODE_EOL: begin
          ctrl_o.clear = 1'b1;
          bil_d        = '0;
          col_d        = '0;
          ens_d        = '0;
          lm_d         = '0;
          if (line_q != nsl_pkg::LINE_MAX) begin
            line_d = line_q + nsl_pkg::LINE_W'(1);
          end
          res_valid_o  = (lm_q != '0);
          res_o.kind   = nsl_pkg::KIND_LINE;
          res_o.count  = nsl_pkg::CNT_W'(lm_q);
        end
        nsl_pkg::MODE_EOT: begin
          ctrl_o.clear = 1'b1;
          bil_d        = '0;
          col_d        = '0;
          ens_d        = '0;
          lm_d         = '0;
          line_d       = nsl_pkg::LINE_W'(1);
          tot_d        = '0;
          res_valid_o  = 1'b1;
          res_o.kind   = nsl_pkg::KIND_TOTAL;
          res_o.count  = tot_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bil_q  <= '0;
      col_q  <= '0;
      ens_q  <= '0;
      line_q <= nsl_pkg::LINE_W'(1);
      lm_q   <= '0;
      tot_q  <= '0;
    end else begin
      bil_q  <= bil_d;
      col_q  <= col_d;
      ens_q  <= ens_d;
      line_q <= line_d;
      lm_q   <= lm_d;
      tot_q  <= tot_d;
    end
  end

`include "nonoverlap_substring_locator_assert.svh"

  `NSL_ASSERT_NOW(a_line_nonzero, 1'b1, line_q != '0, "line number dropped to zero")
  `NSL_ASSERT_NEXT(a_eot_restart, accept_i && mode_i == nsl_pkg::MODE_EOT, line_q == nsl_pkg::LINE_W'(1) && tot_q == '0 && lm_q == '0, "end of text did not restart counters")
  `NSL_ASSERT_NOW(a_hit_after_prev, res_valid_o && res_o.kind == nsl_pkg::KIND_MATCH, start >= ens_q && ens_d > ens_q, "overlapping match reported")
  `NSL_ASSERT_NOW(a_bytes_bounded, 1'b1, bil_q <= nsl_pkg::LEN_W'(MAX_PATTERN), "line byte count past window")

endmodule

`default_nettype wire

// ----- src/nsl_skid.sv -----
`default_nettype none

// Two-entry result buffer: output register plus one skid slot.
module nsl_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  nsl_pkg::report_t data_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nsl_pkg::report_t out_data_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  nsl_pkg::report_t out_q, out_d;
  nsl_pkg::report_t skid_q, skid_d;

  assign ready_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = push_i;
        skid_d       = data_i;
      end else begin
        out_valid_d  = push_i;
        out_d        = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "nonoverlap_substring_locator_assert.svh"

  `NSL_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid slot filled ahead of output")
  `NSL_ASSERT_NEXT(a_stall_keeps_skid, skid_valid_q && out_valid_q && !out_ready_i, skid_valid_q && $stable(skid_q), "stalled skid entry lost")
  `NSL_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready_i, out_valid_q && $stable(out_q), "held report changed")

endmodule

`default_nettype wire
